// ===== sv/bpro_pkg.sv =====
// ----------------------------------------------------------------------------
// bpro_pkg: block partition range and owner lookup package
// Item types, controller states, control/status bundles and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bpro_pkg;

	localparam int MAX_VERTICES = 1048576;
	localparam int MAX_RANKS    = 1024;

	localparam int VERT_W = 21;
	localparam int RCFG_W = 11;
	localparam int RANK_W = 10;
	localparam int DIV_STEPS = VERT_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	// opcodes
	localparam logic OP_RANGE = 1'b0;
	localparam logic OP_OWNER = 1'b1;

	// configuration register indexes
	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_RANK_COUNT   = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [VERT_W-1:0] query_value;
	} query_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] owner_rank;
		logic [VERT_W-1:0] range_low;
		logic [VERT_W-1:0] range_high;
		logic              bad_query;
	} result_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEL,
		ST_CMP,
		ST_LAST,
		ST_DONE
	} bpro_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic cmp;
		logic res;
		logic emit;
	} bpro_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic div_last;
		logic found;
		logic out_free;
	} bpro_sts_t;

endpackage

`default_nettype wire

// ===== sv/bpro_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpro_ctrl: lookup sequencer
// Steps one query through division, binary search and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bpro_ctrl import bpro_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      query_valid,
	output logic           query_ready,
	input  wire bpro_sts_t sts,
	output bpro_cmd_t      cmd
);

	bpro_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		query_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				query_ready = 1'b1;
				if (query_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.bad) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				cmd.mul = 1'b1;
				state_d = sts.found ? ST_LAST : ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_SEL;
			end
			ST_LAST: begin
				cmd.res = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/bpro_dp.sv =====
// ----------------------------------------------------------------------------
// bpro_dp: lookup datapath
// Config registers, restoring divider, search bounds, block bound arithmetic
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpro_dp import bpro_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_index,
	input  wire logic [VERT_W-1:0] cfg_data,
	input  wire query_item_t       query,
	input  wire bpro_cmd_t         cmd,
	output bpro_sts_t              sts,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output result_item_t           result
);

	logic [VERT_W-1:0] vertex_count_q;
	logic [RCFG_W-1:0] rank_count_q;
	logic [VERT_W-1:0] nv_eff;
	logic [RCFG_W-1:0] nr_eff;

	logic [VERT_W-1:0] q_q;
	logic              bad_q;
	logic [RANK_W-1:0] a_q, b_q, rank_q;
	logic [RCFG_W-1:0] rem_q;
	logic [VERT_W-1:0] quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [VERT_W-1:0] prod_q;
	result_item_t      res_q;
	logic              out_valid_q;
	result_item_t      out_q;

	logic              load_bad;
	logic [RCFG_W:0]   div_rr;
	logic              div_ge;
	logic [RCFG_W:0]   div_sub;
	logic [RANK_W:0]   ab_sum;
	logic [RANK_W-1:0] mid;
	logic [RANK_W-1:0] sel_r;
	logic [RANK_W+VERT_W-1:0] mul_full;
	logic              r_lt;
	logic [RANK_W-1:0] extra;
	logic [VERT_W:0]   lo_w, hi_w;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			rank_count_q   <= RCFG_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_VERTEX_COUNT) vertex_count_q <= cfg_data;
			else rank_count_q <= cfg_data[RCFG_W-1:0];
		end
	end

	// clamp config to supported limits
	always_comb begin
		if (rank_count_q == '0) nr_eff = RCFG_W'(1);
		else if (rank_count_q > RCFG_W'(MAX_RANKS)) nr_eff = RCFG_W'(MAX_RANKS);
		else nr_eff = rank_count_q;
		if (vertex_count_q > VERT_W'(MAX_VERTICES)) nv_eff = VERT_W'(MAX_VERTICES);
		else nv_eff = vertex_count_q;
	end

	// range check of the incoming item
	always_comb begin
		if (query.opcode == OP_RANGE) begin
			load_bad = query.query_value >= VERT_W'(nr_eff);
		end else begin
			load_bad = (query.query_value == '0) || (query.query_value > nv_eff);
		end
	end

	// one restoring divide step
	assign div_rr  = {rem_q, quo_q[VERT_W-1]};
	assign div_ge  = div_rr >= {1'b0, nr_eff};
	assign div_sub = div_rr - {1'b0, nr_eff};

	// search midpoint and rank select
	assign ab_sum = {1'b0, a_q} + {1'b0, b_q};
	assign mid    = ab_sum[RANK_W:1];
	assign sel_r  = (a_q == b_q) ? a_q : mid;
	assign mul_full = sel_r * quo_q;

	// block bounds of rank_q: base in quo_q, remainder in rem_q
	assign r_lt  = {1'b0, rank_q} < rem_q;
	assign extra = r_lt ? rank_q : rem_q[RANK_W-1:0];
	assign lo_w  = {1'b0, prod_q} + {{(VERT_W-RANK_W+1){1'b0}}, extra} + (VERT_W+1)'(1);
	assign hi_w  = lo_w + {1'b0, quo_q} + (VERT_W+1)'(r_lt);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q   <= query.query_value;
			rem_q <= '0;
			quo_q <= nv_eff;
			cnt_q <= '0;
			if (query.opcode == OP_RANGE) begin
				a_q <= query.query_value[RANK_W-1:0];
				b_q <= query.query_value[RANK_W-1:0];
			end else begin
				a_q <= '0;
				b_q <= RANK_W'(nr_eff - RCFG_W'(1));
			end
			res_q <= '{owner_rank: '0, range_low: '0, range_high: '0, bad_query: 1'b1};
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_sub[RCFG_W-1:0] : div_rr[RCFG_W-1:0];
			quo_q <= {quo_q[VERT_W-2:0], div_ge};
			cnt_q <= cnt_q + DCNT_W'(1);
		end
		if (cmd.mul) begin
			rank_q <= sel_r;
			prod_q <= mul_full[VERT_W-1:0];
		end
		if (cmd.cmp) begin
			if (q_q < hi_w[VERT_W-1:0]) b_q <= rank_q;
			else a_q <= rank_q + RANK_W'(1);
		end
		if (cmd.res) begin
			res_q <= '{owner_rank: rank_q, range_low: lo_w[VERT_W-1:0],
				range_high: hi_w[VERT_W-1:0], bad_query: 1'b0};
		end
		if (cmd.emit) out_q <= res_q;
	end

	// bad flag of the item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (cmd.load) begin
			bad_q <= load_bad;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.bad      = bad_q;
	assign sts.div_last = cnt_q == DCNT_W'(DIV_STEPS - 1);
	assign sts.found    = (a_q == b_q);
	assign sts.out_free = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== sv/block_partition_range_and_owner.sv =====
// ----------------------------------------------------------------------------
// block_partition_range_and_owner: block distribution owner lookup
// Returns a rank's vertex range, or finds the rank owning a vertex.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   query   | query_valid, query_ready, query           | in
//   result  | result_valid, result_ready, result        | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item at a time. A valid query runs through the bit-serial divider, then
// up to 10 binary-search steps (multiply then compare), then to the output
// register; a range query needs a single multiply and no compare. An
// out-of-range query skips the divider and the search. One multiplier is
// shared by all search steps. A finished item waits in the output register
// while the next query is taken; a finished item holds in its last state
// while the receiver still stalls the one before it.
// Config writes are always accepted. Reset sets vertex_count 0 and
// rank_count 1.
// ----------------------------------------------------------------------------
`default_nettype none

module block_partition_range_and_owner import bpro_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              query_valid,
	output logic                   query_ready,
	input  wire query_item_t       query,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output result_item_t           result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [VERT_W-1:0] cfg_data
);

	bpro_cmd_t cmd;
	bpro_sts_t sts;

	assign cfg_ready = 1'b1;

	bpro_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	bpro_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.query        (query),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== sv/bpro_checker.sv =====
// ----------------------------------------------------------------------------
// bpro_checker: port-level checks
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bpro_checker import bpro_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              query_valid,
	input wire logic              query_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire result_item_t      result
);

	// hold a stalled item
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	// flagged items carry zero fields
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_query |->
		result.owner_rank == '0 && result.range_low == '0 && result.range_high == '0)
		else $error("bad query with nonzero fields");

	// good items have an ordered, 1-indexed range
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.bad_query |->
		result.range_low != '0 && result.range_low <= result.range_high)
		else $error("range bounds out of order");

	// never raise a result on the cycle right after a query is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(query_valid && query_ready))
		else $error("result too soon after query");

endmodule

bind block_partition_range_and_owner bpro_checker u_bpro_checker (.*);

`default_nettype wire
